FILE: hw/rtl/spnn_pkg.sv
// Package for the sorted-points nearest-neighbor block.
// Holds the table depth, the coordinate width and the derived widths.
// Depends on nothing.
package spnn_pkg;
   localparam int MaxPoints = 64;
   localparam int CoordBits = 24;
   localparam int IdBits    = $clog2(MaxPoints);
   localparam int CntBits   = $clog2(MaxPoints + 1);
   localparam int SqBits    = 2 * CoordBits + 1;
   localparam int DiffBits  = CoordBits + 1;
   localparam int PairBits  = 2 * DiffBits + 1;
   localparam int RootBits  = CoordBits + 1;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic [IdBits-1:0]           id_type;
   typedef logic [CntBits-1:0]          cnt_type;
   typedef logic [SqBits-1:0]           sq_type;
   typedef logic [PairBits-1:0]         pair_type;

   typedef struct packed {
      coord_type x_coord;
      coord_type y_coord;
      logic      last_point;
   } req_type;

   typedef struct packed {
      id_type                point_id;
      coord_type             point_x;
      coord_type             point_y;
      logic [CoordBits-1:0]  origin_distance;
      id_type                nearest_id;
      logic                  has_nearest;
      logic                  points_dropped;
      logic                  last_result;
   } rsp_type;
endpackage

FILE: hw/rtl/spnn_if.sv
// Valid/ready channel interface carrying one payload of type T.
// Depends on spnn_pkg.
interface spnn_if #(parameter type T = logic) (input logic clock);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/sorted_points_nearest_neighbor.sv
// Top level: point table sorted by origin distance, nearest-neighbor report.
// Depends on spnn_pkg and spnn_if.
//
//  channel | dir | payload
//  req     | in  | x_coord, y_coord, last_point
//  rsp     | out | point_id, point_x, point_y, origin_distance, nearest_id, flags
//
// A point is squared in ST_SQX and ST_SQY on the one shared multiplier, then
// ST_INS moves up each stored entry with a larger distance and inserts the point,
// and ST_OPEN closes; a point that finds the table full is dropped and flagged.
// Output: per point, a load, a neighbor scan over every table entry (ST_DX,
// ST_DY), 25 square-root steps and a send, with one multiplier.
// Reset is synchronous; no clearing pass. A stalled rsp holds the sequencer.
module sorted_points_nearest_neighbor (
   input logic clock,
   input logic reset,
   spnn_if.sink   req,
   spnn_if.source rsp
);
   import spnn_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_SQX   = 10'b0000000010,
      ST_SQY   = 10'b0000000100,
      ST_INS   = 10'b0000001000,
      ST_OPEN  = 10'b0000010000,
      ST_LOAD  = 10'b0000100000,
      ST_DX    = 10'b0001000000,
      ST_DY    = 10'b0010000000,
      ST_ROOT  = 10'b0100000000,
      ST_SEND  = 10'b1000000000
   } state_type;

   // one table entry, kept in sorted order
   typedef struct packed {
      id_type    id;
      coord_type x;
      coord_type y;
      sq_type    sq;
   } entry_type;

   // storage
   entry_type mem_tab [MaxPoints];
   entry_type tab_rd_ff;
   entry_type tab_wd;
   id_type    tab_ra;
   id_type    tab_wa;
   logic      tab_we;

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   logic      over_ff, over_in;
   logic      last_ff, last_in;
   cnt_type   i_ff, i_in;
   cnt_type   j_ff, j_in;
   sq_type    sq_ff, sq_in;
   sq_type    acc_ff, acc_in;
   coord_type px_ff, px_in, py_ff, py_in;
   id_type    pid_ff, pid_in;
   logic      found_ff, found_in;
   id_type    best_ff, best_in;
   pair_type  bd_ff, bd_in;
   pair_type  dxx_ff, dxx_in;
   sq_type    rem_ff, rem_in;
   logic [RootBits-1:0] root_ff, root_in;
   logic [5:0] step_ff, step_in;
   rsp_type   out_ff, out_in;
   logic      ov_ff, ov_in;

   // shared multiplier: squares the magnitude of its operand
   logic signed [DiffBits-1:0] mul_a;
   logic [DiffBits-2:0]        mul_m;
   logic [2*DiffBits-3:0]      mul_p;

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = ov_ff;
   assign rsp.data  = out_ff;

   assign mul_m = mul_a[DiffBits-1] ? (DiffBits-1)'(-mul_a) : mul_a[DiffBits-2:0];
   assign mul_p = mul_m * mul_m;

   // sqrt trial value: (root << (step+1)) | (1 << 2*step), as root holds
   // only bits above step this equals the classic (root+bit) form.
   logic [SqBits+1:0] trial;
   always_comb begin
      trial = ((SqBits+2)'(root_ff) << (32'(step_ff) + 32'd1))
              | ((SqBits+2)'(1) << (32'(step_ff) * 32'd2));
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; over_in = over_ff;
      last_in = last_ff; i_in = i_ff; j_in = j_ff; sq_in = sq_ff;
      acc_in = acc_ff; px_in = px_ff; py_in = py_ff; pid_in = pid_ff;
      found_in = found_ff; best_in = best_ff; bd_in = bd_ff;
      dxx_in = dxx_ff; rem_in = rem_ff; root_in = root_ff; step_in = step_ff;
      out_in = out_ff; ov_in = ov_ff;
      mul_a = '0; tab_we = 1'b0; tab_wa = '0; tab_wd = '0; tab_ra = '0;
      if (ov_ff && rsp.ready) ov_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               px_in = req.data.x_coord; py_in = req.data.y_coord;
               last_in = req.data.last_point;
               if (count_ff < cnt_type'(MaxPoints)) begin
                  state_in = ST_SQX;
               end else begin
                  over_in = 1'b1;
                  state_in = ST_OPEN;
               end
            end
         end
         ST_SQX: begin
            mul_a = DiffBits'(px_ff);
            acc_in = SqBits'(mul_p);
            state_in = ST_SQY;
         end
         // fetch the last entry for the insertion walk
         ST_SQY: begin
            mul_a = DiffBits'(py_ff);
            sq_in = acc_ff + SqBits'(mul_p);
            tab_ra = IdBits'(count_ff - 1'b1);
            j_in = count_ff;
            state_in = ST_INS;
         end
         // walk down from the end, moving up entries with larger distance
         ST_INS: begin
            tab_we = 1'b1;
            tab_wa = j_ff[IdBits-1:0];
            if (j_ff != '0 && tab_rd_ff.sq > sq_ff) begin
               tab_wd = tab_rd_ff;
               tab_ra = IdBits'(j_ff - 2'd2);
               j_in = j_ff - 1'b1;
            end else begin
               tab_wd = '{id: count_ff[IdBits-1:0], x: px_ff, y: py_ff, sq: sq_ff};
               count_in = count_ff + 1'b1;
               state_in = ST_OPEN;
            end
         end
         ST_OPEN: begin
            if (!last_ff) state_in = ST_IDLE;
            else if (count_ff == '0) begin
               over_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               i_in = '0;
               tab_ra = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            pid_in = tab_rd_ff.id;
            px_in = tab_rd_ff.x; py_in = tab_rd_ff.y;
            rem_in = tab_rd_ff.sq;
            found_in = 1'b0; best_in = '0; j_in = '0;
            tab_ra = '0;
            state_in = ST_DX;
         end
         ST_DX: begin
            tab_ra = j_ff[IdBits-1:0];
            if (j_ff == count_ff) begin
               root_in = '0;
               step_in = 6'(RootBits - 1);
               state_in = ST_ROOT;
            end else begin
               mul_a = DiffBits'(px_ff) - DiffBits'(tab_rd_ff.x);
               dxx_in = PairBits'(mul_p);
               state_in = ST_DY;
            end
         end
         ST_DY: begin
            tab_ra = IdBits'(j_ff + 1'b1);
            mul_a = DiffBits'(py_ff) - DiffBits'(tab_rd_ff.y);
            if (!(tab_rd_ff.x == px_ff && tab_rd_ff.y == py_ff) &&
                (!found_ff || (dxx_ff + PairBits'(mul_p)) < bd_ff)) begin
               found_in = 1'b1; best_in = tab_rd_ff.id;
               bd_in = dxx_ff + PairBits'(mul_p);
            end
            j_in = j_ff + 1'b1;
            state_in = ST_DX;
         end
         // restoring square root, one result bit per cycle
         ST_ROOT: begin
            if ({2'b0, rem_ff} >= trial) begin
               rem_in = SqBits'({2'b0, rem_ff} - trial);
               root_in = root_ff | (RootBits'(1) << step_ff);
            end
            if (step_ff == '0) state_in = ST_SEND;
            else step_in = step_ff - 1'b1;
         end
         ST_SEND: begin
            tab_ra = IdBits'(i_ff + 1'b1);
            if (!ov_ff || rsp.ready) begin
               out_in.point_id = pid_ff;
               out_in.point_x = px_ff;
               out_in.point_y = py_ff;
               out_in.origin_distance = CoordBits'(root_ff);
               out_in.nearest_id = best_ff;
               out_in.has_nearest = found_ff;
               out_in.points_dropped = over_ff;
               out_in.last_result = (i_ff + 1'b1 == count_ff);
               ov_in = 1'b1;
               if (i_ff + 1'b1 == count_ff) begin
                  count_in = '0; over_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (tab_we) mem_tab[tab_wa] <= tab_wd;
      tab_rd_ff <= mem_tab[tab_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; over_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; over_ff <= over_in;
         ov_ff <= ov_in;
      end
      last_ff <= last_in; i_ff <= i_in; j_ff <= j_in; sq_ff <= sq_in;
      acc_ff <= acc_in; px_ff <= px_in; py_ff <= py_in; pid_ff <= pid_in;
      found_ff <= found_in; best_ff <= best_in; bd_ff <= bd_in;
      dxx_ff <= dxx_in; rem_ff <= rem_in; root_ff <= root_in;
      step_ff <= step_in; out_ff <= out_in;
   end
endmodule

FILE: hw/rtl/spnn_checker.sv
// Port-level checker for the nearest-neighbor block, bound to the top level.
// Depends on spnn_pkg.
module spnn_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input spnn_pkg::rsp_type rsp_data
);
   import spnn_pkg::*;

   // a result never reports a neighbor when the flag is clear
   a_no_nb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_nearest |-> rsp_data.nearest_id == '0)
      else $error("nearest_id set without neighbor");

   // a point is never its own neighbor
   a_self: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.has_nearest |-> rsp_data.nearest_id != rsp_data.point_id)
      else $error("point reported as own neighbor");

   // no new point taken while results are being sent
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |-> !req_ready)
      else $error("input taken during output");

   // an accepted point closes the input for the next cycle
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input open right after a transfer");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
endmodule

bind sorted_points_nearest_neighbor spnn_checker u_spnn_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
